>>> src/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int DBL_BITS  = 2 * WORD_BITS;
  localparam int ALU_BITS  = DBL_BITS + 1;
  localparam int CNT_BITS  = $clog2(DBL_BITS);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_FORM = 7'b0000100,
    S_GCD  = 7'b0001000,
    S_DIVN = 7'b0010000,
    S_DIVD = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [ALU_BITS-1:0] diff;
    logic                ge;
  } alu_res_t;

endpackage

>>> src/rau_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_mul
// registered unsigned word by word multiplier
// ----------------------------------------------------------------------------
module rau_mul
  import rau_pkg::*;
(
  input  logic                 clk,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic [DBL_BITS-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= DBL_BITS'(a) * DBL_BITS'(b);
  end

endmodule

>>> src/rau_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_alu
// shared subtract and compare unit for fraction forming, gcd and division steps
// ----------------------------------------------------------------------------
module rau_alu
  import rau_pkg::*;
(
  input  logic [ALU_BITS-1:0] a,
  input  logic [ALU_BITS-1:0] b,
  output alu_res_t            res
);

  logic [ALU_BITS:0] full;

  assign full     = {1'b0, a} - {1'b0, b};
  assign res.diff = full[ALU_BITS-1:0];
  assign res.ge   = ~full[ALU_BITS];

endmodule

>>> src/rational_arith_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// exact fraction add, subtract, multiply and divide with gcd reduction
// ----------------------------------------------------------------------------
// One item at a time. After a transfer in, four cross products go through one
// shared multiplier, the raw fraction is formed, a binary gcd runs on the
// shared subtractor (one step a cycle), then numerator and denominator are
// each divided by the gcd bit-serially, and the range check is applied in
// S_OUT. Zero results and error cases skip the gcd and division. in_ready is
// high only while idle; the result is held until transferred out.
module rational_arith_unit_core
  import rau_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic signed [WORD_BITS-1:0] num_a,
  input  logic [WORD_BITS-1:0]        den_a,
  input  logic signed [WORD_BITS-1:0] num_b,
  input  logic [WORD_BITS-1:0]        den_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] num_r,
  output logic [WORD_BITS-1:0]        den_r,
  output logic                        is_less,
  output logic                        is_equal,
  output logic                        is_greater,
  output logic [1:0]                  status
);

  state_t                state;
  op_t                   op;
  logic [WORD_BITS-1:0]  na, da, nb, db;
  logic [DBL_BITS-1:0]   p1, p2, p3, p4, prod;
  logic [DBL_BITS-1:0]   x, y, g, rem, q, rnv, rdv;
  logic [CNT_BITS-1:0]   k, cnt;
  logic                  rneg;

  logic [WORD_BITS-1:0]  ma, mb, mul_a, mul_b;
  logic [ALU_BITS-1:0]   alu_a, alu_b, div_r;
  alu_res_t              alu;

  logic                  f_err, s1, s2, lneg, rneg_c, f_neg;
  logic [DBL_BITS-1:0]   f_rn, f_rd;
  logic                  c_less, c_eq, c_gt;
  logic                  ovf;
  logic [WORD_BITS-1:0]  rn_lo;

  logic signed [WORD_BITS-1:0] num_reg;
  logic [WORD_BITS-1:0]        den_reg;
  logic [1:0]                  st_reg;
  logic signed [WORD_BITS-1:0] num_fin;
  logic [WORD_BITS-1:0]        den_fin;
  logic [1:0]                  st_fin;

  assign ma = na[WORD_BITS-1] ? (~na + 1'b1) : na;
  assign mb = nb[WORD_BITS-1] ? (~nb + 1'b1) : nb;

  always_comb begin
    case (cnt[1:0])
      2'd0:    begin mul_a = ma; mul_b = db; end
      2'd1:    begin mul_a = mb; mul_b = da; end
      2'd2:    begin mul_a = da; mul_b = db; end
      default: begin mul_a = ma; mul_b = mb; end
    endcase
  end

  rau_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  assign div_r = {rem, q[DBL_BITS-1]};

  always_comb begin
    alu_a = {1'b0, p1};
    alu_b = {1'b0, p2};
    if (state == S_GCD) begin
      alu_a = {1'b0, x};
      alu_b = {1'b0, y};
    end else if (state == S_DIVN || state == S_DIVD) begin
      alu_a = div_r;
      alu_b = {1'b0, g};
    end
  end

  rau_alu u_alu (.a(alu_a), .b(alu_b), .res(alu));

  // raw fraction and operand compare
  always_comb begin
    f_err  = (da == '0) || (db == '0) || (op == OP_DIV && nb == '0);
    s1     = na[WORD_BITS-1];
    s2     = nb[WORD_BITS-1] ^ (op == OP_SUB);
    f_neg  = na[WORD_BITS-1] ^ nb[WORD_BITS-1];
    f_rd   = p3;
    case (op) inside
      OP_ADD, OP_SUB: begin
        if (s1 == s2) begin
          f_rn  = p1 + p2;
          f_neg = s1;
        end else if (alu.ge) begin
          f_rn  = alu.diff[DBL_BITS-1:0];
          f_neg = s1;
        end else begin
          f_rn  = ~alu.diff[DBL_BITS-1:0] + 1'b1;
          f_neg = s2;
        end
      end
      OP_MUL:  f_rn = p4;
      default: begin
        f_rn = p1;
        f_rd = p2;
      end
    endcase
    lneg   = na[WORD_BITS-1] && (p1 != '0);
    rneg_c = nb[WORD_BITS-1] && (p2 != '0);
    c_eq   = 1'b0;
    if (lneg != rneg_c) begin
      c_less = lneg;
      c_gt   = rneg_c;
    end else begin
      c_eq   = (p1 == p2);
      c_less = lneg ? (alu.ge && !c_eq) : !alu.ge;
      c_gt   = !c_less && !c_eq;
    end
  end

  assign rn_lo = rnv[WORD_BITS-1:0];
  assign ovf   = (rneg ? (rnv > (DBL_BITS'(1) << (WORD_BITS - 1)))
                       : (rnv > ((DBL_BITS'(1) << (WORD_BITS - 1)) - 1'b1)))
                 || (q[DBL_BITS-1:WORD_BITS] != '0);

  always_comb begin
    if (ovf) begin
      num_fin = '0;
      den_fin = WORD_BITS'(1);
      st_fin  = ST_OVF;
    end else begin
      num_fin = rneg ? (~rn_lo + 1'b1) : rn_lo;
      den_fin = q[WORD_BITS-1:0];
      st_fin  = ST_OK;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= op_t'(req_type);
            na    <= num_a;
            da    <= den_a;
            nb    <= num_b;
            db    <= den_b;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          case (cnt[2:0])
            3'd1:    p1 <= prod;
            3'd2:    p2 <= prod;
            3'd3:    p3 <= prod;
            3'd4:    p4 <= prod;
            default: ;
          endcase
          cnt <= cnt + 1'b1;
          if (cnt[2:0] == 3'd4) state <= S_FORM;
        end
        S_FORM: begin
          is_less    <= c_less;
          is_equal   <= c_eq;
          is_greater <= c_gt;
          num_reg    <= '0;
          den_reg    <= WORD_BITS'(1);
          if (f_err) begin
            st_reg    <= ST_DIV0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else if (f_rn == '0) begin
            st_reg    <= ST_OK;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            x     <= f_rn;
            y     <= f_rd;
            rnv   <= f_rn;
            rdv   <= f_rd;
            rneg  <= f_neg;
            k     <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (x == '0) begin
            g     <= y << k;
            rem   <= '0;
            q     <= rnv;
            cnt   <= '0;
            state <= S_DIVN;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (alu.ge) begin
            x <= alu.diff[DBL_BITS-1:0];
          end else begin
            x <= y;
            y <= x;
          end
        end
        S_DIVN, S_DIVD: begin
          cnt <= cnt + 1'b1;
          if (state == S_DIVN && cnt == CNT_BITS'(DBL_BITS - 1)) begin
            rnv   <= {q[DBL_BITS-2:0], alu.ge};
            q     <= rdv;
            rem   <= '0;
            state <= S_DIVD;
          end else begin
            rem <= alu.ge ? alu.diff[DBL_BITS-1:0] : div_r[DBL_BITS-1:0];
            q   <= {q[DBL_BITS-2:0], alu.ge};
            if (cnt == CNT_BITS'(DBL_BITS - 1)) state <= S_OUT;
          end
        end
        S_OUT: begin
          // range check and final result once both quotients are in
          if (!out_valid) begin
            num_reg   <= num_fin;
            den_reg   <= den_fin;
            st_reg    <= st_fin;
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign num_r  = num_reg;
  assign den_r  = den_reg;
  assign status = st_reg;

endmodule

>>> src/rau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// port level checks of the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_checker
  import rau_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [WORD_BITS-1:0] num_r,
  input logic [WORD_BITS-1:0]        den_r,
  input logic                        is_less,
  input logic                        is_equal,
  input logic                        is_greater,
  input logic [1:0]                  status
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(num_r) && $stable(den_r))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({is_less, is_equal, is_greater}))
    else $error("compare flags not one-hot");

  a_err_res: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> num_r == '0 && den_r == WORD_BITS'(1))
    else $error("error result not zero over one");

  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> den_r != '0)
    else $error("zero result denominator");

endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .num_r(num_r), .den_r(den_r), .is_less(is_less),
  .is_equal(is_equal), .is_greater(is_greater), .status(status)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rational arithmetic unit
// ----------------------------------------------------------------------------
// Directed corner operands go in first, then random fractions: small and
// full-width values, with zero, unit and reducible cases mixed in. Each
// accepted request gets its reduced fraction, compare flags and status worked
// out in the bench and queued. Every result that comes out is checked against
// the oldest entry in that queue. Both sides pause at random, and once the
// result side holds off for a long stretch so that the unit stalls its input.
// ----------------------------------------------------------------------------
module testbench
  import rau_pkg::*;
();

  typedef struct {
    op_t                  op;
    logic [WORD_BITS-1:0] na, da, nb, db;
  } frac_req_t;

  typedef struct {
    logic [WORD_BITS-1:0] num, den;
    logic                 lt, eq, gt;
    status_t              st;
  } frac_res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] req_type = 0;
  logic signed [WORD_BITS-1:0] num_a = 0, num_b = 0;
  logic [WORD_BITS-1:0] den_a = 1, den_b = 1;
  logic out_valid;
  logic out_ready = 0;
  logic signed [WORD_BITS-1:0] num_r;
  logic [WORD_BITS-1:0] den_r;
  logic is_less, is_equal, is_greater;
  logic [1:0] status;

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  int        n_errors = 0;
  int        n_results = 0;
  int        n_sent = 0;
  bit        stim_done = 0;
  bit        hold_active = 0;
  longint    cycle_count = 0;
  int        send_gap = 0;
  int        recv_gap = 0;

  rational_arith_unit_core dut (.*);

  always #1 clk = ~clk;

  function automatic logic [127:0] gcd_of(logic [127:0] x, logic [127:0] y);
    logic [127:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // exact fraction arithmetic at double width
  function automatic frac_res_t predict_frac(frac_req_t r);
    frac_res_t    e;
    longint       sa, sb, lhs, rhs;
    logic [127:0] ma, mb, m1, m2, rn, rd, g;
    bit           s1, s2, neg;
    sa = longint'($signed(r.na));
    sb = longint'($signed(r.nb));
    ma = (sa < 0) ? -sa : sa;
    mb = (sb < 0) ? -sb : sb;
    lhs = sa * longint'({32'd0, r.db});
    rhs = sb * longint'({32'd0, r.da});
    e.lt = lhs < rhs;
    e.eq = lhs == rhs;
    e.gt = lhs > rhs;
    e.st = ST_OK;
    rn = 0;
    rd = 1;
    neg = 0;
    if (r.da == 0 || r.db == 0 || (r.op == OP_DIV && r.nb == 0)) begin
      e.st = ST_DIV0;
    end else if (r.op == OP_ADD || r.op == OP_SUB) begin
      m1 = ma * r.db;
      m2 = mb * r.da;
      s1 = sa < 0;
      s2 = (sb < 0) != (r.op == OP_SUB);
      if (s1 == s2) begin
        rn = m1 + m2;
        neg = s1;
      end else if (m1 >= m2) begin
        rn = m1 - m2;
        neg = s1;
      end else begin
        rn = m2 - m1;
        neg = s2;
      end
      rd = r.da * r.db;
    end else if (r.op == OP_MUL) begin
      rn = ma * mb;
      rd = r.da * r.db;
      neg = (sa < 0) != (sb < 0);
    end else begin
      rn = ma * r.db;
      rd = r.da * mb;
      neg = (sa < 0) != (sb < 0);
    end
    if (e.st == ST_OK) begin
      if (rn == 0) begin
        rd = 1;
        neg = 0;
      end else begin
        g = gcd_of(rn, rd);
        rn = rn / g;
        rd = rd / g;
      end
      if ((neg ? rn > 128'h8000_0000 : rn > 128'h7fff_ffff) || rd > 128'hffff_ffff)
        e.st = ST_OVF;
    end
    if (e.st != ST_OK) begin
      rn = 0;
      rd = 1;
      neg = 0;
    end
    e.num = neg ? -rn[31:0] : rn[31:0];
    e.den = rd[31:0];
    return e;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return -$urandom_range(0, 20);
      2: return $urandom_range(0, 5000);
      3: return -$urandom_range(0, 5000);
      4: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_req(op_t op, logic [31:0] na, logic [31:0] da,
                           logic [31:0] nb, logic [31:0] db);
    frac_req_t r;
    r.op = op;
    r.na = na;
    r.da = da;
    r.nb = nb;
    r.db = db;
    pending_reqs.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("mismatch at result %0d: %s got %h expected %h", n_results, what, got, want);
  endtask

  initial begin
    logic [31:0] k, da, db;
    queue_req(OP_ADD, 32'h7fffffff, 1, 32'h7fffffff, 1);
    queue_req(OP_SUB, 32'h80000000, 1, 32'h7fffffff, 1);
    queue_req(OP_MUL, 32'h80000000, 1, 32'h80000000, 1);
    queue_req(OP_MUL, 32'h80000000, 1, 32'hffffffff, 1);
    queue_req(OP_DIV, 32'h80000000, 1, 32'hffffffff, 1);
    queue_req(OP_DIV, 5, 7, 0, 3);
    queue_req(OP_ADD, 1, 0, 1, 1);
    queue_req(OP_MUL, -3, 2, 4, 0);
    queue_req(OP_SUB, 3, 4, 3, 4);
    queue_req(OP_ADD, 1, 32'hffffffff, 1, 32'hfffffffe);
    queue_req(OP_DIV, 1, 32'hffffffff, 32'h7fffffff, 32'hffffffff);
    queue_req(OP_MUL, 0, 32'hffffffff, -7, 3);
    queue_req(OP_ADD, -1, 2, 1, 2);
    queue_req(OP_DIV, -6, 4, 9, 2);
    queue_req(OP_SUB, 2, 6, -5, 15);
    queue_req(OP_MUL, 32'h7fffffff, 32'hffffffff, 32'h7fffffff, 32'hffffffff);
    queue_req(OP_ADD, 32'h80000000, 32'hffffffff, 32'h80000000, 32'hffffffff);
    queue_req(OP_SUB, 0, 1, 0, 32'hffffffff);
    queue_req(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 1);
    queue_req(OP_ADD, 0, 0, 0, 0);
    for (int i = 0; i < 500; i++) begin
      k = $urandom_range(1, 12);
      da = (i % 25 == 0) ? 0 : rand_word();
      db = rand_word();
      if (da == 0 && i % 25 != 0) da = 1;
      if (db == 0 && $urandom_range(0, 9) != 0) db = k;
      if ($urandom_range(0, 3) == 0) da = da * k;
      queue_req(op_t'($urandom_range(0, 3)), rand_word(), da, rand_word(), db);
    end
    stim_done = 1;
  end

  // request driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 10) rst <= 0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_fracs.push_back(predict_frac(pending_reqs.pop_front()));
        n_sent <= n_sent + 1;
        send_gap <= pick_gap();
        in_valid <= 0;
      end else if (!in_valid && send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (!in_valid && pending_reqs.size() > 0) begin
        in_valid <= 1;
        req_type <= pending_reqs[0].op;
        num_a <= pending_reqs[0].na;
        den_a <= pending_reqs[0].da;
        num_b <= pending_reqs[0].nb;
        den_b <= pending_reqs[0].db;
      end
    end
  end

  // long hold-off on the result side so the unit backs up
  initial begin
    wait (n_sent == 40);
    hold_active = 1;
    repeat (2000) @(posedge clk);
    hold_active = 0;
  end

  // result monitor
  always @(posedge clk) begin
    frac_res_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (expected_fracs.size() == 0) begin
          n_errors++;
          $display("result transfer with nothing expected");
        end else begin
          e = expected_fracs.pop_front();
          if (num_r !== e.num) report_mismatch("num_r", num_r, e.num);
          if (den_r !== e.den) report_mismatch("den_r", den_r, e.den);
          if (is_less !== e.lt) report_mismatch("is_less", is_less, e.lt);
          if (is_equal !== e.eq) report_mismatch("is_equal", is_equal, e.eq);
          if (is_greater !== e.gt) report_mismatch("is_greater", is_greater, e.gt);
          if (status !== e.st) report_mismatch("status", status, e.st);
        end
      end
      if (hold_active) begin
        out_ready <= 0;
      end else if (recv_gap > 0) begin
        out_ready <= 0;
        recv_gap <= recv_gap - 1;
      end else if (out_valid && out_ready) begin
        out_ready <= 0;
        recv_gap <= pick_gap();
      end else begin
        out_ready <= 1;
      end
    end
  end

  initial begin
    wait (stim_done && pending_reqs.size() == 0 && !in_valid
          && expected_fracs.size() == 0 && !rst);
    repeat (400) @(posedge clk);
    $display("ran %0d requests over all four operations, incl. zero denominators,",
             n_sent);
    $display("divide by zero, overflow and a long result stall; %0d results checked",
             n_results);
    if (n_errors == 0 && expected_fracs.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    wait (cycle_count == 2000000);
    $display("timeout with %0d results outstanding", expected_fracs.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
